// ----- rtl/a64dp_pkg.sv -----
// a64dp_pkg: shared types and constants for the aarch64 data-processing alu
// no dependencies
`default_nettype none

package a64dp_pkg;

	localparam int unsigned XLEN       = 64;
	localparam int unsigned REG_ADDR_W = 5;
	localparam int unsigned FLAGS_W    = 4;
	localparam int unsigned INSTR_W    = 32;
	localparam int unsigned REG_DEPTH  = 31;

	localparam logic [REG_ADDR_W-1:0] ZERO_REG = 5'h1F;

	typedef enum logic [1:0] {
		OP_EXEC  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [XLEN-1:0]       value;
		logic                  flags_we;
		logic [FLAGS_W-1:0]    flags_nxt;
		logic                  rf_we;
		logic [REG_ADDR_W-1:0] rf_waddr;
		logic [XLEN-1:0]       rf_wdata;
		logic                  executed;
	} exec_res_t;

endpackage

`default_nettype wire

// ----- rtl/aarch64_data_processing_register_alu.sv -----
// aarch64_data_processing_register_alu: top level of the register-alu execute unit
// inputs and register reads are registered, then the result once the output is free
// one item at a time: register file read, then alu and write-back
// reset: registers read as zero and flags clear at once, no clearing pass
// uses a64dp_pkg, a64dp_regfile, a64dp_exec
`default_nettype none

module aarch64_data_processing_register_alu import a64dp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,  // instruction, reg_index, write_value, zero pad
	input  wire logic [1:0]   s_axis_tuser,  // operation
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [71:0]  m_axis_tdata,  // read_value, flags, zero pad
	output logic              m_axis_tuser   // executed
);

	logic                  in_beat;
	op_t                   in_op;
	logic [INSTR_W-1:0]    in_instr;
	logic [REG_ADDR_W-1:0] in_idx;
	logic [REG_ADDR_W-1:0] ra_addr;

	logic                  busy_s1;
	op_t                   op_s1;
	logic [INSTR_W-1:0]    instr_s1;
	logic [REG_ADDR_W-1:0] idx_s1;
	logic [XLEN-1:0]       wval_s1;
	logic                  done_s1;

	logic [XLEN-1:0]       ra_data;
	logic [XLEN-1:0]       rb_data;
	exec_res_t             res;

	logic [FLAGS_W-1:0]    flags_q;
	logic [FLAGS_W-1:0]    flags_nxt;
	logic                  out_valid_q;
	logic [XLEN-1:0]       out_value_q;
	logic [FLAGS_W-1:0]    out_flags_q;
	logic                  out_exec_q;

	assign s_axis_tready = !busy_s1;
	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign in_op    = op_t'(s_axis_tuser);
	assign in_instr = s_axis_tdata[31:0];
	assign in_idx   = s_axis_tdata[36:32];
	assign ra_addr  = (in_op == OP_EXEC) ? in_instr[9:5] : in_idx;

	assign done_s1  = busy_s1 && (!out_valid_q || m_axis_tready);

	a64dp_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_beat),
		.ra_addr (ra_addr),
		.rb_addr (in_instr[20:16]),
		.ra_data (ra_data),
		.rb_data (rb_data),
		.we      (done_s1 && res.rf_we),
		.waddr   (res.rf_waddr),
		.wdata   (res.rf_wdata)
	);

	a64dp_exec u_exec (
		.op          (op_s1),
		.instr       (instr_s1),
		.reg_index   (idx_s1),
		.write_value (wval_s1),
		.a           (ra_data),
		.b_raw       (rb_data),
		.res         (res)
	);

	assign flags_nxt = res.flags_we ? res.flags_nxt : flags_q;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_s1    <= in_op;
			instr_s1 <= in_instr;
			idx_s1   <= in_idx;
			wval_s1  <= s_axis_tdata[100:37];
		end
		if (done_s1) begin
			out_value_q <= res.value;
			out_flags_q <= flags_nxt;
			out_exec_q  <= res.executed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat) begin
				busy_s1 <= 1'b1;
			end else if (done_s1) begin
				busy_s1 <= 1'b0;
			end
			if (done_s1) begin
				flags_q     <= flags_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_flags_q, out_value_q};
	assign m_axis_tuser  = out_exec_q;

endmodule

`default_nettype wire

// ----- rtl/a64dp_regfile.sv -----
// a64dp_regfile: 31 x 64 register file, two synchronous read ports, one write port
// index 31 reads zero; valid bits give the all-zero reset; uses a64dp_pkg
`default_nettype none

module a64dp_regfile import a64dp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [REG_ADDR_W-1:0] ra_addr,
	input  wire logic [REG_ADDR_W-1:0] rb_addr,
	output logic      [XLEN-1:0]       ra_data,
	output logic      [XLEN-1:0]       rb_data,
	input  wire logic                  we,
	input  wire logic [REG_ADDR_W-1:0] waddr,
	input  wire logic [XLEN-1:0]       wdata
);

	logic [XLEN-1:0]      mem [REG_DEPTH];
	logic [REG_DEPTH-1:0] valid_q;
	logic [XLEN-1:0]      ra_raw_q;
	logic [XLEN-1:0]      rb_raw_q;
	logic                 ra_zero_q;
	logic                 rb_zero_q;

	always_ff @(posedge clk) begin
		if (we && waddr != ZERO_REG) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			ra_raw_q <= mem[ra_addr];
			rb_raw_q <= mem[rb_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			ra_zero_q <= 1'b1;
			rb_zero_q <= 1'b1;
		end else begin
			if (we && waddr != ZERO_REG) begin
				valid_q[waddr] <= 1'b1;
			end
			if (rd_en) begin
				ra_zero_q <= (ra_addr == ZERO_REG) || !valid_q[ra_addr];
				rb_zero_q <= (rb_addr == ZERO_REG) || !valid_q[rb_addr];
			end
		end
	end

	assign ra_data = ra_zero_q ? '0 : ra_raw_q;
	assign rb_data = rb_zero_q ? '0 : rb_raw_q;

endmodule

`default_nettype wire

// ----- rtl/a64dp_exec.sv -----
// a64dp_exec: decode, operand shift and alu for one item
// uses a64dp_pkg
`default_nettype none

module a64dp_exec import a64dp_pkg::*; (
	input  wire op_t                   op,
	input  wire logic [INSTR_W-1:0]    instr,
	input  wire logic [REG_ADDR_W-1:0] reg_index,
	input  wire logic [XLEN-1:0]       write_value,
	input  wire logic [XLEN-1:0]       a,
	input  wire logic [XLEN-1:0]       b_raw,
	output exec_res_t                  res
);

	localparam logic [4:0] CLS_ADDSUB = 5'b01011;
	localparam logic [4:0] CLS_LOGIC  = 5'b01010;
	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] LG_ORR = 2'd1;
	localparam logic [1:0] LG_EOR = 2'd2;
	localparam logic [1:0] LG_ANDS = 2'd3;

	logic [4:0]          cls;
	logic                nbit;
	logic [1:0]          sh;
	logic [5:0]          amt;
	logic [1:0]          opc;
	logic [XLEN-1:0]     b;
	logic [2*XLEN-1:0]   rot;
	logic [XLEN-1:0]     bb_as;
	logic [XLEN:0]       sum;
	logic [XLEN-1:0]     s;
	logic                vflag;
	logic [XLEN-1:0]     bb_lg;
	logic [XLEN-1:0]     lg;

	assign cls  = instr[28:24];
	assign nbit = instr[21];
	assign sh   = instr[23:22];
	assign amt  = instr[15:10];
	assign opc  = instr[30:29];
	assign rot  = {b_raw, b_raw} >> amt;

	always_comb begin
		case (sh)
			SH_LSL:  b = b_raw << amt;
			SH_LSR:  b = b_raw >> amt;
			SH_ASR:  b = XLEN'($signed(b_raw) >>> amt);
			default: b = rot[XLEN-1:0];
		endcase
	end

	assign bb_as = opc[1] ? ~b : b;
	assign sum   = {1'b0, a} + {1'b0, bb_as} + {{XLEN{1'b0}}, opc[1]};
	assign s     = sum[XLEN-1:0];
	assign vflag = (a[XLEN-1] ^ s[XLEN-1]) & (bb_as[XLEN-1] ^ s[XLEN-1]);

	assign bb_lg = nbit ? ~b : b;
	always_comb begin
		case (opc)
			LG_ORR:  lg = a | bb_lg;
			LG_EOR:  lg = a ^ bb_lg;
			default: lg = a & bb_lg;
		endcase
	end

	always_comb begin
		res = '0;
		unique case (op)
			OP_EXEC: begin
				if (cls == CLS_ADDSUB && !nbit) begin
					res.value     = s;
					res.flags_we  = opc[0];
					res.flags_nxt = {s[XLEN-1], s == '0, sum[XLEN], vflag};
					res.rf_we     = 1'b1;
					res.rf_waddr  = instr[4:0];
					res.rf_wdata  = s;
					res.executed  = 1'b1;
				end else if (cls == CLS_LOGIC) begin
					res.value     = lg;
					res.flags_we  = (opc == LG_ANDS);
					res.flags_nxt = {lg[XLEN-1], lg == '0, 2'b00};
					res.rf_we     = 1'b1;
					res.rf_waddr  = instr[4:0];
					res.rf_wdata  = lg;
					res.executed  = 1'b1;
				end
			end
			OP_WRITE: begin
				res.rf_we    = 1'b1;
				res.rf_waddr = reg_index;
				res.rf_wdata = write_value;
			end
			OP_READ: begin
				res.value = a;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/a64dp_checker.sv -----
// a64dp_checker: port-level assertions for the register-alu execute unit
// bound to aarch64_data_processing_register_alu; uses a64dp_pkg
`default_nettype none

module a64dp_checker import a64dp_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [103:0] s_axis_tdata,
	input wire logic [1:0]   s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [71:0]  m_axis_tdata,
	input wire logic         m_axis_tuser
);

	logic in_beat;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// one item in flight at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_axis_tready)
		else $error("input accepted while an item is in flight");

	// result follows when the output is free
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat ##1 (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
		else $error("result beat missing");

	// zero register reads as zero
	a_zero_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && s_axis_tuser == OP_READ && s_axis_tdata[36:32] == ZERO_REG
			##1 (!m_axis_tvalid || m_axis_tready)
			|=> m_axis_tdata[63:0] == '0 && !m_axis_tuser)
		else $error("zero register read returned non-zero");

endmodule

bind aarch64_data_processing_register_alu a64dp_checker u_a64dp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- test/tb_aarch64_data_processing_register_alu.sv -----
// tb_aarch64_data_processing_register_alu: self-checking bench for the register alu
// drives directed then random beats through the input stream; a scoreboard predicts
// each result and checks the output stream; needs a64dp_pkg and the alu rtl only
`default_nettype none

module tb_aarch64_data_processing_register_alu;
	timeunit 1ns;
	timeprecision 1ps;
	import a64dp_pkg::*;

	localparam logic [4:0] CLASS_ADDSUB = 5'b01011;
	localparam logic [4:0] CLASS_LOGIC  = 5'b01010;
	localparam logic [1:0] SHIFT_LSL = 2'd0;
	localparam logic [1:0] SHIFT_LSR = 2'd1;
	localparam logic [1:0] SHIFT_ASR = 2'd2;
	localparam logic [1:0] SHIFT_ROR = 2'd3;
	localparam logic [1:0] LOGIC_AND = 2'd0;
	localparam logic [1:0] LOGIC_ORR = 2'd1;
	localparam logic [1:0] LOGIC_EOR = 2'd2;
	localparam logic [1:0] LOGIC_ANDS = 2'd3;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned ITEMS_PER_PHASE = 450;

	typedef struct {
		logic [63:0] value;
		logic [3:0]  flags;
		logic        executed;
	} alu_result_t;

	class alu_scoreboard;
		logic [63:0]  xreg [31];
		logic [3:0]   nzcv;
		alu_result_t  pending_results [$];
		int unsigned  errors;

		function new();
			foreach (xreg[i]) xreg[i] = '0;
			nzcv = '0;
			errors = 0;
		endfunction

		function logic [63:0] reg_value(logic [4:0] idx);
			return (idx == ZERO_REG) ? 64'd0 : xreg[idx];
		endfunction

		function void retire_input(op_t op, logic [31:0] ins, logic [4:0] idx, logic [63:0] wv);
			alu_result_t res;
			logic [63:0] a, b, bb, r, ovf;
			logic [64:0] sum;
			logic [5:0]  amt;
			logic        sub;
			res.value = '0;
			res.executed = 1'b0;
			r = '0;
			a = reg_value(ins[9:5]);
			b = reg_value(ins[20:16]);
			amt = ins[15:10];
			if (amt != 6'd0) begin
				case (ins[23:22])
					SHIFT_LSL: b = b << amt;
					SHIFT_LSR: b = b >> amt;
					SHIFT_ASR: b = $unsigned($signed(b) >>> amt);
					default:   b = (b >> amt) | (b << (7'd64 - {1'b0, amt}));
				endcase
			end
			case (op)
				OP_WRITE: if (idx != ZERO_REG) xreg[idx] = wv;
				OP_READ:  res.value = reg_value(idx);
				OP_EXEC: begin
					if (ins[28:24] == CLASS_ADDSUB && !ins[21]) begin
						sub = ins[30];
						bb = sub ? ~b : b;
						sum = {1'b0, a} + {1'b0, bb} + {64'd0, sub};
						r = sum[63:0];
						ovf = (a ^ r) & (bb ^ r);
						if (ins[29]) nzcv = {r[63], r == 64'd0, sum[64], ovf[63]};
						res.executed = 1'b1;
					end else if (ins[28:24] == CLASS_LOGIC) begin
						bb = ins[21] ? ~b : b;
						case (ins[30:29])
							LOGIC_ORR: r = a | bb;
							LOGIC_EOR: r = a ^ bb;
							default:   r = a & bb;
						endcase
						if (ins[30:29] == LOGIC_ANDS) nzcv = {r[63], r == 64'd0, 2'b00};
						res.executed = 1'b1;
					end
					if (res.executed) begin
						res.value = r;
						if (ins[4:0] != ZERO_REG) xreg[ins[4:0]] = r;
					end
				end
				default: ;
			endcase
			res.flags = nzcv;
			pending_results.push_back(res);
		endfunction

		function void check_output(logic [63:0] value, logic [3:0] flags, logic executed);
			alu_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual value %h flags %h executed %b",
					$time, value, flags, executed);
				return;
			end
			want = pending_results.pop_front();
			if (value !== want.value) begin
				errors++;
				$display("%0t: read_value expected %h actual %h", $time, want.value, value);
			end
			if (flags !== want.flags) begin
				errors++;
				$display("%0t: flags expected %h actual %h", $time, want.flags, flags);
			end
			if (executed !== want.executed) begin
				errors++;
				$display("%0t: executed expected %b actual %b", $time, want.executed, executed);
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;  // instruction, reg_index, write_value, zero pad
	logic [1:0]   s_axis_tuser;  // operation
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;  // read_value, flags, zero pad
	logic         m_axis_tuser;  // executed

	alu_scoreboard sb = new();
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_idle_pct = 0;
	bit            hold_req = 1'b0;
	int unsigned   quiet_cycles = 0;

	aarch64_data_processing_register_alu uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] rnd_value();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] enc_addsub(logic sub, logic setf, logic [1:0] sh,
			logic [4:0] rm, logic [5:0] amt, logic [4:0] rn, logic [4:0] rd);
		logic [31:0] r;
		r = $urandom;
		return {r[0], sub, setf, CLASS_ADDSUB, sh, 1'b0, rm, amt, rn, rd};
	endfunction

	function automatic logic [31:0] enc_logic(logic [1:0] opc, logic n, logic [1:0] sh,
			logic [4:0] rm, logic [5:0] amt, logic [4:0] rn, logic [4:0] rd);
		logic [31:0] r;
		r = $urandom;
		return {r[0], opc, CLASS_LOGIC, sh, n, rm, amt, rn, rd};
	endfunction

	task automatic send_item(op_t op, logic [31:0] ins, logic [4:0] idx, logic [63:0] wv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = {3'b000, wv, idx, ins};
		s_axis_tuser = op;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_output(m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.retire_input(op_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[36:32],
					s_axis_tdata[100:37]);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// long hold-off so the input side backs up
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		int unsigned phase, n, sel, kind;
		logic [31:0] r1, r2, ins;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_NONE;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		send_item(OP_WRITE, $urandom, 5'd0, '1);
		send_item(OP_WRITE, $urandom, 5'd1, 64'd1);
		send_item(OP_WRITE, $urandom, 5'd2, 64'h8000_0000_0000_0000);
		send_item(OP_WRITE, $urandom, 5'd3, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(OP_WRITE, $urandom, ZERO_REG, {$urandom, $urandom});
		send_item(OP_READ, $urandom, ZERO_REG, {$urandom, $urandom});
		send_item(OP_READ, $urandom, 5'd3, {$urandom, $urandom});
		send_item(OP_EXEC, enc_addsub(1'b0, 1'b1, SHIFT_LSL, 5'd1, 6'd0, 5'd3, 5'd4), 5'd0, '0);
		send_item(OP_EXEC, enc_addsub(1'b0, 1'b1, SHIFT_LSL, 5'd1, 6'd0, 5'd0, 5'd5), 5'd0, '0);
		send_item(OP_EXEC, enc_addsub(1'b1, 1'b1, SHIFT_LSL, 5'd1, 6'd0, 5'd2, 5'd6), 5'd0, '0);
		// zero register on every operand and as destination
		send_item(OP_EXEC, enc_addsub(1'b1, 1'b1, SHIFT_LSR, ZERO_REG, 6'd5, ZERO_REG, ZERO_REG),
			5'd0, '0);
		send_item(OP_EXEC, enc_addsub(1'b0, 1'b0, SHIFT_LSR, 5'd0, 6'd63, 5'd1, 5'd7), 5'd0, '0);
		send_item(OP_EXEC, enc_addsub(1'b1, 1'b0, SHIFT_ASR, 5'd2, 6'd63, 5'd1, 5'd8), 5'd0, '0);
		// rotate on add/sub uses the reserved shift code
		send_item(OP_EXEC, enc_addsub(1'b0, 1'b0, SHIFT_ROR, 5'd2, 6'd1, ZERO_REG, 5'd9), 5'd0, '0);
		send_item(OP_EXEC, enc_logic(LOGIC_AND, 1'b0, SHIFT_LSL, 5'd3, 6'd63, 5'd0, 5'd10), 5'd0, '0);
		send_item(OP_EXEC, enc_logic(LOGIC_AND, 1'b1, SHIFT_LSL, 5'd1, 6'd0, 5'd0, 5'd11), 5'd0, '0);
		send_item(OP_EXEC, enc_logic(LOGIC_ORR, 1'b0, SHIFT_ROR, 5'd1, 6'd4, 5'd2, 5'd12), 5'd0, '0);
		send_item(OP_EXEC, enc_logic(LOGIC_ORR, 1'b1, SHIFT_LSR, 5'd3, 6'd1, 5'd1, 5'd13), 5'd0, '0);
		send_item(OP_EXEC, enc_logic(LOGIC_EOR, 1'b0, SHIFT_LSL, 5'd0, 6'd8, 5'd3, 5'd14), 5'd0, '0);
		send_item(OP_EXEC, enc_logic(LOGIC_EOR, 1'b1, SHIFT_ASR, 5'd2, 6'd32, 5'd1, 5'd15), 5'd0, '0);
		send_item(OP_EXEC, enc_logic(LOGIC_ANDS, 1'b0, SHIFT_LSL, 5'd2, 6'd0, 5'd0, 5'd16), 5'd0, '0);
		send_item(OP_EXEC, enc_logic(LOGIC_ANDS, 1'b1, SHIFT_LSL, 5'd0, 6'd0, 5'd0, 5'd17), 5'd0, '0);
		// add/sub with bit 21 set and a word of no known class
		send_item(OP_EXEC, enc_addsub(1'b0, 1'b1, SHIFT_LSL, 5'd1, 6'd0, 5'd1, 5'd18) | 32'h0020_0000,
			5'd0, '0);
		send_item(OP_EXEC, 32'h0000_0000, 5'd0, '0);
		send_item(OP_NONE, $urandom, 5'd4, {$urandom, $urandom});
		send_item(OP_READ, $urandom, 5'd4, {$urandom, $urandom});

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  hold_req = 1'b1; end
				1: begin send_idle_pct = 48; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 48; end
				default: begin send_idle_pct = 24; recv_idle_pct = 24; end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				sel = $urandom_range(0, 99);
				r1 = $urandom;
				r2 = $urandom;
				if (sel < 15) begin
					send_item(OP_WRITE, r1, r2[4:0], rnd_value());
				end else if (sel < 30) begin
					send_item(OP_READ, r1, r2[4:0], rnd_value());
				end else if (sel < 34) begin
					send_item(OP_NONE, r1, r2[4:0], rnd_value());
				end else begin
					kind = $urandom_range(0, 99);
					if (kind < 45)
						ins = enc_addsub(r1[0], r1[1], r1[3:2], r1[8:4], r1[14:9], r1[19:15],
							r1[24:20]);
					else if (kind < 90)
						ins = enc_logic(r1[1:0], r1[2], r1[4:3], r1[9:5], r1[15:10], r1[20:16],
							r1[25:21]);
					else
						ins = r1;
					send_item(OP_EXEC, ins, r2[4:0], rnd_value());
				end
			end
		end
		s_axis_tvalid = 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/a64dp_pkg.sv
rtl/a64dp_regfile.sv
rtl/a64dp_exec.sv
rtl/aarch64_data_processing_register_alu.sv
rtl/a64dp_checker.sv
test/tb_aarch64_data_processing_register_alu.sv
